// File: hw/rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and constants of the slide window check
// Holds the fixed field widths, the register indexes, the reset values of the
// configuration registers and the word that travels down the row of cells.
// ----------------------------------------------------------------------------
package swmm_pkg;

    // Address arithmetic is done at 49 bits so that no window or descriptor
    // end ever wraps.
    localparam int ADDR_W     = 49;
    localparam int START_W    = 48;
    localparam int PAGES_W    = 36;
    localparam int PAGE_SHIFT = 12;
    localparam int BASE_W     = 32;
    localparam int STEP_W     = 24;
    localparam int SPAN_W     = 32;
    localparam int COV_W      = SPAN_W + 1;
    localparam int MASK_W     = 64;
    localparam int COUNT_W    = 9;
    localparam int CHUNK_W    = 2;
    localparam int CHUNK_MAX  = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Slides from this number up move past the reserved graphics range in
    // the alternate CPU mode.
    localparam int                UPPER_SLIDE_FIRST = 128;
    localparam logic [BASE_W-1:0] UPPER_SLIDE_SHIFT = 32'h1020_0000;

    localparam logic [BASE_W-1:0] BASE_RESET = 32'h0010_0000;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'h20_0000;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 32'h0200_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ALT_CPU_MODE = 3'd0,
        REG_KERNEL_BASE  = 3'd1,
        REG_SLIDE_STEP   = 3'd2,
        REG_KERNEL_SPAN  = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic              alt_cpu_mode;
        logic [BASE_W-1:0] kernel_base;
        logic [STEP_W-1:0] slide_step;
        logic [SPAN_W-1:0] kernel_span;
    } cfg_t;

    // One descriptor on its way down the row, together with the window of the
    // cell that it is about to visit.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              free;
        logic [ADDR_W-1:0] dstart;
        logic [ADDR_W-1:0] dend;
        logic [ADDR_W-1:0] wstart;
        logic [ADDR_W-1:0] wend;
    } item_t;

endpackage

// File: hw/rtl/slide_window_memory_map_check_core.sv
// ----------------------------------------------------------------------------
// slide_window_memory_map_check_core: slide window memory map check
// Finds every kernel slide whose window lies wholly in free memory, from a
// memory map streamed one descriptor word at a time.
// ----------------------------------------------------------------------------
// Usage. Descriptor words enter on the s_ channel, one per cycle while
// s_tready is high; s_tlast marks the final descriptor of a map. Each word
// travels down a row of SLIDE_COUNT cells, one cell per cycle, and every cell
// checks it against the window of its own slide. After the final descriptor
// the input is closed until the answer is out: once the final word has left
// the last cell, the block enters its emit state and loads the first answer
// word into the output register. The answer is (SLIDE_COUNT + 63) / 64 words
// on the m_ channel, one per 64 slides, each with the total count of valid
// slides; m_tlast marks the final one. The input reopens in the cycle after
// the final answer word is loaded into the output register. A stalled
// receiver holds the answer word in the output register; the row keeps its
// result bits until the next map's final descriptor passes. Reset loads the
// register defaults, sets every ok bit, clears every free byte count and
// empties the row. The user must write registers on the cfg_ port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module slide_window_memory_map_check_core #(
    parameter int SLIDE_COUNT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [swmm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [swmm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Descriptor input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [87:0]                         s_tdata,  // desc_start[47:0], desc_pages[83:48]
    input  logic                                s_tuser,  // is_free
    input  logic                                s_tlast,  // last_desc
    // Answer output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [79:0]                         m_tdata,  // valid_mask[63:0], valid_count[72:64]
    output logic [swmm_pkg::CHUNK_W-1:0]        m_tuser,  // chunk_index
    output logic                                m_tlast   // last_chunk
);
    import swmm_pkg::*;

    localparam int CNT_W   = $clog2(SLIDE_COUNT + 1);
    localparam int NCHUNK  = (SLIDE_COUNT + 63) / 64;
    localparam int RES_W   = CHUNK_MAX * MASK_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    cfg_t                 cfg_reg;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHUNK_W-1:0]   m_chunk_reg;
    logic [MASK_W-1:0]    m_mask_reg;
    logic [COUNT_W-1:0]   m_count_reg;
    logic                 m_last_reg;

    item_t                item_head;
    item_t                item_w [SLIDE_COUNT];
    logic [CNT_W-1:0]     cnt_w  [SLIDE_COUNT + 1];
    logic [RES_W-1:0]     res_vec;
    logic [MASK_W-1:0]    chunk_words [CHUNK_MAX];
    logic                 fin_last;
    logic                 accept;
    logic                 load;
    logic                 chunk_is_last;

    // ------------------------------------------------------------------
    // Configuration registers. Indexes outside the list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alt_cpu_mode <= 1'b0;
            cfg_reg.kernel_base  <= BASE_RESET;
            cfg_reg.slide_step   <= STEP_RESET;
            cfg_reg.kernel_span  <= SPAN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ALT_CPU_MODE: cfg_reg.alt_cpu_mode <= cfg_wdata[0];
                REG_KERNEL_BASE:  cfg_reg.kernel_base  <= cfg_wdata[BASE_W-1:0];
                REG_SLIDE_STEP:   cfg_reg.slide_step   <= cfg_wdata[STEP_W-1:0];
                REG_KERNEL_SPAN:  cfg_reg.kernel_span  <= cfg_wdata[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Entry into the row. The descriptor end and the slide zero window are
    // worked out here; every cell then adds the step (and any upper slide shift) for its neighbor.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        item_head.valid  = accept;
        item_head.last   = s_tlast;
        item_head.free   = s_tuser;
        item_head.dstart = {1'b0, s_tdata[START_W-1:0]};
        item_head.dend   = {1'b0, s_tdata[START_W-1:0]}
                         + {1'b0, s_tdata[START_W+PAGES_W-1:START_W], {PAGE_SHIFT{1'b0}}};
        item_head.wstart = ADDR_W'(cfg_reg.kernel_base);
        item_head.wend   = ADDR_W'(cfg_reg.kernel_base) + ADDR_W'(cfg_reg.kernel_span);
    end

    assign item_w[0] = item_head;
    assign cnt_w[0]  = '0;

    // ------------------------------------------------------------------
    // The row of slide cells.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < SLIDE_COUNT; i++) begin : g_cell
        if (i < SLIDE_COUNT - 1) begin : g_mid
            swmm_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cfg      (cfg_reg),
                .item_in  (item_w[i]),
                .item_out (item_w[i+1]),
                .cnt_in   (cnt_w[i]),
                .cnt_out  (cnt_w[i+1]),
                .fin      (),
                .res      (res_vec[i])
            );
        end else begin : g_end
            swmm_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cfg      (cfg_reg),
                .item_in  (item_w[i]),
                .item_out (),
                .cnt_in   (cnt_w[i]),
                .cnt_out  (cnt_w[i+1]),
                .fin      (fin_last),
                .res      (res_vec[i])
            );
        end
    end

    // Slides past the configured count read as not valid.
    for (genvar p = SLIDE_COUNT; p < RES_W; p++) begin : g_pad
        assign res_vec[p] = 1'b0;
    end

    for (genvar c = 0; c < CHUNK_MAX; c++) begin : g_word
        assign chunk_words[c] = res_vec[c*MASK_W +: MASK_W];
    end

    // ------------------------------------------------------------------
    // Control: take descriptors, wait for the final one to clear the row,
    // then load the answer words into the output register.
    // ------------------------------------------------------------------
    assign chunk_is_last = (chunk_reg == CHUNK_W'(NCHUNK - 1));
    assign load          = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        chunk_next   = chunk_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (fin_last) begin
                    state_next = ST_EMIT;
                    chunk_next = '0;
                end
            end
            ST_EMIT: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    chunk_next   = chunk_reg + CHUNK_W'(1);
                    if (chunk_is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chunk_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chunk_reg   <= chunk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_chunk_reg <= chunk_reg;
            m_mask_reg  <= chunk_words[chunk_reg];
            m_count_reg <= COUNT_W'(cnt_w[SLIDE_COUNT]);
            m_last_reg  <= chunk_is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_count_reg, m_mask_reg};
    assign m_tuser  = m_chunk_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // The input closes right after the final descriptor of a map.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after the final descriptor");

    // The final descriptor leaves the row only while the block waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_last |-> (state_reg == ST_DRAIN))
        else $error("final descriptor left the row outside the drain state");

    // The final answer word carries the highest chunk number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == CHUNK_W'(NCHUNK - 1)))
        else $error("last answer word has the wrong chunk number");

    // The count never exceeds the number of slides.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[72:64] <= COUNT_W'(SLIDE_COUNT)))
        else $error("valid slide count out of range");

endmodule

// File: hw/rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell: one slide of the window check
// Holds the ok bit and the free byte count of one slide window, applies each
// passing descriptor in two steps and hands the descriptor to the next cell.
// ----------------------------------------------------------------------------
module swmm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  swmm_pkg::cfg_t    cfg,
    input  swmm_pkg::item_t   item_in,
    output swmm_pkg::item_t   item_out,
    input  logic [CNT_W-1:0]  cnt_in,
    output logic [CNT_W-1:0]  cnt_out,
    output logic              fin,
    output logic              res
);
    import swmm_pkg::*;

    // In the alternate CPU mode the next slide's window jumps by the extra
    // shift when it is the first upper slide.
    localparam logic [ADDR_W-1:0] SHIFT_ADD =
        (IDX + 1 == UPPER_SLIDE_FIRST) ? ADDR_W'(UPPER_SLIDE_SHIFT) : '0;

    item_t              item_reg;
    logic               a_valid_reg;
    logic               a_last_reg;
    logic               a_hit_reg;
    logic               a_free_reg;
    logic [SPAN_W-1:0]  a_ovl_reg;
    logic               ok_reg;
    logic [COV_W-1:0]   cov_reg;
    logic               res_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               hit;
    logic [ADDR_W-1:0]  lo;
    logic [ADDR_W-1:0]  hi;
    logic [ADDR_W-1:0]  ovl_full;
    logic [ADDR_W-1:0]  inc;
    logic [COV_W:0]     sum;
    logic [COV_W:0]     span_wide;
    logic               upd;
    logic               kill;
    logic               ok_next;
    logic [COV_W-1:0]   cov_next;
    logic               valid_bit;
    logic               fin_now;

    // First step: overlap test and clipped overlap length.
    always_comb begin
        hit = (item_reg.dstart < item_reg.wend) && (item_reg.dend > item_reg.wstart);
        lo  = (item_reg.dstart > item_reg.wstart) ? item_reg.dstart : item_reg.wstart;
        hi  = (item_reg.dend < item_reg.wend) ? item_reg.dend : item_reg.wend;
        ovl_full = hi - lo;
    end

    // Window of the following cell.
    always_comb begin
        inc = ADDR_W'(cfg.slide_step) + (cfg.alt_cpu_mode ? SHIFT_ADD : '0);
        item_out        = item_reg;
        item_out.wstart = item_reg.wstart + inc;
        item_out.wend   = item_reg.wend + inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
            a_valid_reg    <= 1'b0;
        end else begin
            item_reg    <= item_in;
            a_valid_reg <= item_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        a_last_reg <= item_reg.last;
        a_hit_reg  <= hit;
        a_free_reg <= item_reg.free;
        a_ovl_reg  <= ovl_full[SPAN_W-1:0];
    end

    // Second step: fold the overlap into the slide state. The count saturates
    // one above the span so that an excess never reads as an exact fit.
    always_comb begin
        sum       = {1'b0, cov_reg} + (COV_W + 1)'(a_ovl_reg);
        span_wide = (COV_W + 1)'(cfg.kernel_span);
        upd       = a_valid_reg && a_hit_reg && a_free_reg;
        kill      = a_valid_reg && a_hit_reg && !a_free_reg;
        ok_next   = ok_reg && !kill;
        if (!upd) begin
            cov_next = cov_reg;
        end else if (sum > span_wide) begin
            cov_next = COV_W'(cfg.kernel_span) + COV_W'(1);
        end else begin
            cov_next = sum[COV_W-1:0];
        end
        valid_bit = ok_next && (upd ? (sum == span_wide)
                                    : (cov_reg == COV_W'(cfg.kernel_span)));
        fin_now   = a_valid_reg && a_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg  <= 1'b1;
            cov_reg <= '0;
        end else if (fin_now) begin
            ok_reg  <= 1'b1;
            cov_reg <= '0;
        end else begin
            ok_reg  <= ok_next;
            cov_reg <= cov_next;
        end
    end

    // The running count of valid slides follows the final descriptor down
    // the row one cell behind it.
    always_ff @(posedge aclk) begin
        if (fin_now) begin
            res_reg <= valid_bit;
            cnt_reg <= cnt_in + CNT_W'(valid_bit);
        end
    end

    assign cnt_out = cnt_reg;
    assign res     = res_reg;
    assign fin     = fin_now;

endmodule
